@@ design/itrd_pkg.sv @@
// Package for the integer-to-radix digit emitter: widths, limits, payload and control types.
package itrd_pkg;

   localparam int MAX_DIGITS = 64;
   localparam int MAX_RADIX  = 64;

   localparam int VALUE_W = 64;
   localparam int RADIX_W = 7;
   localparam int DIGIT_W = 6;

   // Largest usable radix: bounded by the digit field as well as by MAX_RADIX.
   localparam int RADIX_TOP_INT = (MAX_RADIX < 64) ? MAX_RADIX : 64;
   localparam int STACK_DEPTH   = (MAX_DIGITS < 64) ? MAX_DIGITS : 64;
   localparam int STACK_AW      = $clog2(STACK_DEPTH);
   localparam int COUNT_W       = $clog2(STACK_DEPTH + 1);

   // Quotient bits retired per clock by the divider, and divider steps per digit.
   localparam int BITS_PER_STEP = 8;
   localparam int DIV_STEPS     = VALUE_W / BITS_PER_STEP;
   localparam int STEP_W        = $clog2(DIV_STEPS);

   localparam logic [RADIX_W-1:0] RADIX_TOP   = RADIX_W'(RADIX_TOP_INT);
   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

   localparam logic MODE_SIGNED32   = 1'b0;
   localparam logic MODE_UNSIGNED64 = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic               is_minus;
      logic [DIGIT_W-1:0] digit;
      logic               last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_PUSH,
      ST_MINUS,
      ST_MINUS_WAIT,
      ST_READ,
      ST_EMIT,
      ST_DIGIT_WAIT
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic push;
      logic read;
      logic emit_minus;
      logic emit_digit;
      logic dec;
   } cmd_type;

   typedef struct packed {
      logic step_last;
      logic quot_zero;
      logic stack_full;
      logic negative;
      logic at_last;
      logic out_taken;
   } status_type;

endpackage

@@ design/itrd_ctrl.sv @@
// Controller state machine: sequences load, division, digit push, minus marker and digit output.
module itrd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  itrd_pkg::status_type status,
   output itrd_pkg::cmd_type    cmd
);

   itrd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itrd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         itrd_pkg::ST_IDLE: begin
            if (req_valid) state_in = itrd_pkg::ST_DIVIDE;
         end
         itrd_pkg::ST_DIVIDE: begin
            if (status.step_last) state_in = itrd_pkg::ST_PUSH;
         end
         itrd_pkg::ST_PUSH: begin
            if (status.quot_zero || status.stack_full) begin
               state_in = status.negative ? itrd_pkg::ST_MINUS : itrd_pkg::ST_READ;
            end else begin
               state_in = itrd_pkg::ST_DIVIDE;
            end
         end
         itrd_pkg::ST_MINUS:      state_in = itrd_pkg::ST_MINUS_WAIT;
         itrd_pkg::ST_MINUS_WAIT: begin
            if (status.out_taken) state_in = itrd_pkg::ST_READ;
         end
         itrd_pkg::ST_READ:       state_in = itrd_pkg::ST_EMIT;
         itrd_pkg::ST_EMIT:       state_in = itrd_pkg::ST_DIGIT_WAIT;
         itrd_pkg::ST_DIGIT_WAIT: begin
            if (status.out_taken) begin
               state_in = status.at_last ? itrd_pkg::ST_IDLE : itrd_pkg::ST_READ;
            end
         end
         default: state_in = itrd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         itrd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         itrd_pkg::ST_DIVIDE:     cmd.div_step   = 1'b1;
         itrd_pkg::ST_PUSH:       cmd.push       = 1'b1;
         itrd_pkg::ST_MINUS:      cmd.emit_minus = 1'b1;
         itrd_pkg::ST_MINUS_WAIT: ;
         itrd_pkg::ST_READ:       cmd.read       = 1'b1;
         itrd_pkg::ST_EMIT:       cmd.emit_digit = 1'b1;
         itrd_pkg::ST_DIGIT_WAIT: cmd.dec        = status.out_taken && !status.at_last;
         default: ;
      endcase
   end

endmodule

@@ design/itrd_datapath.sv @@
// Datapath: radix register, restoring divider, digit stack and result register.
module itrd_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [itrd_pkg::RADIX_W-1:0]        csr_data,
   input  itrd_pkg::req_type                   req_payload,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output itrd_pkg::rsp_type                   rsp_payload,
   input  itrd_pkg::cmd_type                   cmd,
   output itrd_pkg::status_type                status
);

   logic [itrd_pkg::RADIX_W-1:0] radix_ff;
   logic [itrd_pkg::RADIX_W-1:0] radix_eff;
   logic [itrd_pkg::VALUE_W-1:0] quot_ff, quot_in;
   logic [itrd_pkg::RADIX_W-1:0] rem_ff, rem_in;
   logic [itrd_pkg::STEP_W-1:0]  step_ff;
   logic [itrd_pkg::COUNT_W-1:0] count_ff;
   logic                         negative_ff;
   logic [itrd_pkg::DIGIT_W-1:0] rd_data_ff;
   logic                         rsp_valid_ff;
   itrd_pkg::rsp_type            rsp_data_ff;
   logic [itrd_pkg::VALUE_W-1:0] magnitude;
   logic [31:0]                  low_word;
   logic [itrd_pkg::COUNT_W-1:0] rd_count;

   logic [itrd_pkg::DIGIT_W-1:0] stack_mem [itrd_pkg::STACK_DEPTH];

   // Clamp the radix into the usable range.
   always_comb begin
      if (radix_ff < itrd_pkg::RADIX_MIN) begin
         radix_eff = itrd_pkg::RADIX_MIN;
      end else if (radix_ff > itrd_pkg::RADIX_TOP) begin
         radix_eff = itrd_pkg::RADIX_TOP;
      end else begin
         radix_eff = radix_ff;
      end
   end

   // Magnitude of the incoming number.
   always_comb begin
      low_word = req_payload.value[31:0];
      if (req_payload.mode == itrd_pkg::MODE_UNSIGNED64) begin
         magnitude = req_payload.value;
      end else if (low_word[31]) begin
         magnitude = itrd_pkg::VALUE_W'(32'(32'd0 - low_word));
      end else begin
         magnitude = itrd_pkg::VALUE_W'(low_word);
      end
   end

   // Restoring division, several quotient bits per clock.
   always_comb begin
      logic [itrd_pkg::RADIX_W-1:0] r;
      logic [itrd_pkg::VALUE_W-1:0] q;
      r = rem_ff;
      q = quot_ff;
      for (int i = 0; i < itrd_pkg::BITS_PER_STEP; i++) begin
         r = {r[itrd_pkg::RADIX_W-2:0], q[itrd_pkg::VALUE_W-1]};
         q = {q[itrd_pkg::VALUE_W-2:0], 1'b0};
         if (r >= radix_eff) begin
            r    = r - radix_eff;
            q[0] = 1'b1;
         end
      end
      rem_in  = r;
      quot_in = q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= itrd_pkg::RADIX_RESET;
      end else if (csr_valid && csr_ready) begin
         radix_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_ff     <= '0;
         rem_ff      <= '0;
         step_ff     <= '0;
         count_ff    <= '0;
         negative_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            quot_ff     <= magnitude;
            rem_ff      <= '0;
            step_ff     <= '0;
            count_ff    <= '0;
            negative_ff <= (req_payload.mode == itrd_pkg::MODE_SIGNED32) && low_word[31];
         end
         if (cmd.div_step) begin
            quot_ff <= quot_in;
            rem_ff  <= rem_in;
            step_ff <= step_ff + 1'b1;
         end
         if (cmd.push) begin
            rem_ff   <= '0;
            step_ff  <= '0;
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.dec) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign rd_count = count_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem[count_ff[itrd_pkg::STACK_AW-1:0]] <= rem_ff[itrd_pkg::DIGIT_W-1:0];
      end
      if (cmd.read) begin
         rd_data_ff <= stack_mem[rd_count[itrd_pkg::STACK_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_minus || cmd.emit_digit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_minus) begin
         rsp_data_ff.is_minus <= 1'b1;
         rsp_data_ff.digit    <= '0;
         rsp_data_ff.last     <= 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_data_ff.is_minus <= 1'b0;
         rsp_data_ff.digit    <= rd_data_ff;
         rsp_data_ff.last     <= status.at_last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assign status.step_last  = step_ff == itrd_pkg::STEP_W'(itrd_pkg::DIV_STEPS - 1);
   assign status.quot_zero  = quot_ff == '0;
   assign status.stack_full = count_ff == itrd_pkg::COUNT_W'(itrd_pkg::STACK_DEPTH - 1);
   assign status.negative   = negative_ff;
   assign status.at_last    = count_ff == itrd_pkg::COUNT_W'(1);
   assign status.out_taken  = rsp_valid_ff && rsp_ready;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= itrd_pkg::COUNT_W'(itrd_pkg::STACK_DEPTH))
      else $error("digit count beyond stack depth");

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> rem_ff < radix_eff)
      else $error("division remainder not below radix");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.is_minus |-> !rsp_data_ff.last)
      else $error("minus marker flagged as last result");

   a_no_emit_over_pending: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_minus || cmd.emit_digit) |-> !rsp_valid_ff)
      else $error("result overwritten before it was taken");

endmodule

@@ design/integer_to_radix_digits.sv @@
// Top level of the integer-to-radix digit emitter: controller plus datapath.
//
// Usage:
//   csr_valid/csr_ready/csr_data write the radix (reset value 10). Values
//   below 2 act as 2, values above 64 act as 64. Write it only while idle.
//   req_valid/req_ready/req_payload take one request: mode 0 converts the
//   low 32 bits as a signed number, mode 1 converts all 64 bits unsigned.
//   rsp_valid/rsp_ready/rsp_payload give one result per digit, most
//   significant first; a negative signed number first gives a minus marker.
//   The final result of a request carries last.
//
// Flow: the request is taken, then each digit is worked out in the divider
// (8 quotient bits per pass of the compare and subtract chain) and pushed
// onto the stack. Each digit is then read from the stack memory into a
// register and presented in the output register; a minus marker goes
// straight to the output register ahead of them. One request at a time.
// When the receiver stalls, the current result holds in the output register
// and the block waits. Reset returns to idle with no result pending and the
// radix at 10.
module integer_to_radix_digits (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [itrd_pkg::RADIX_W-1:0] csr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  itrd_pkg::req_type            req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output itrd_pkg::rsp_type            rsp_payload
);

   itrd_pkg::cmd_type    cmd;
   itrd_pkg::status_type status;

   // Radix writes never stall.
   assign csr_ready = 1'b1;

   itrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   itrd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .req_payload (req_payload),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

@@ test/integer_to_radix_digits_tb.sv @@
// Testbench for integer_to_radix_digits: random and directed requests checked digit by digit.
module integer_to_radix_digits_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // A radix-2 conversion of a full 64-bit value plus the receiver's long
   // hold-off stays far below this many quiet cycles.
   localparam int IDLE_LIMIT     = 20000;
   localparam int SQUEEZE_CYCLES = 1500;
   localparam int SETTLE_CYCLES  = 30;
   localparam int ITEMS_PER_PASS = 27;
   localparam int PRINT_CAP      = 40;

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         csr_valid   = 1'b0;
   logic                         csr_ready;
   logic [itrd_pkg::RADIX_W-1:0] csr_data    = '0;
   logic                         req_valid   = 1'b0;
   logic                         req_ready;
   itrd_pkg::req_type            req_payload = '0;
   logic                         rsp_valid;
   logic                         rsp_ready   = 1'b0;
   itrd_pkg::rsp_type            rsp_payload;

   // Requests waiting for the driver, and digits the block still owes us.
   itrd_pkg::req_type number_queue[$];
   itrd_pkg::rsp_type digits_expected[$];

   // Radix as the block holds it, tracked at each accepted register write.
   logic [itrd_pkg::RADIX_W-1:0] radix_setting = itrd_pkg::RADIX_RESET;

   bit sender_steady   = 1'b0;
   bit receiver_steady = 1'b0;
   int squeeze_requests = 0;
   int squeeze_served   = 0;
   int squeeze_left     = 0;
   int send_gap         = 0;
   int recv_gap         = 0;
   int idle_cycles      = 0;
   int error_count      = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   integer_to_radix_digits DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Mostly no gap or a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 15);
      return $urandom_range(40, 300);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      // Cap the printout so a badly broken block cannot flood the log.
      if (error_count < PRINT_CAP)
         $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Work out the digit stream for one request under the current radix:
   // divide the magnitude repeatedly, least significant digit first onto a
   // stack, then pop most significant first behind an optional minus marker.
   function automatic void predict_digits(itrd_pkg::req_type item);
      logic [itrd_pkg::VALUE_W-1:0] magnitude;
      logic [itrd_pkg::RADIX_W-1:0] base;
      logic                         negative;
      logic [itrd_pkg::DIGIT_W-1:0] stack [itrd_pkg::STACK_DEPTH];
      int                           count;
      itrd_pkg::rsp_type            entry;
      base = radix_setting;
      // Clamp the base: below two acts as two, above the top acts as the top.
      if (base < itrd_pkg::RADIX_MIN) base = itrd_pkg::RADIX_MIN;
      if (base > itrd_pkg::RADIX_TOP) base = itrd_pkg::RADIX_TOP;
      negative = 1'b0;
      if (item.mode == itrd_pkg::MODE_SIGNED32) begin
         // Drop the upper half; the most negative value needs no shortcut here.
         negative  = item.value[31];
         magnitude = negative ? 64'h1_0000_0000 - {32'd0, item.value[31:0]}
                              : {32'd0, item.value[31:0]};
      end else begin
         magnitude = item.value;
      end
      count = 0;
      do begin
         stack[count] = itrd_pkg::DIGIT_W'(magnitude % base);
         magnitude    = magnitude / base;
         count++;
      end while (magnitude != 0 && count < itrd_pkg::STACK_DEPTH);
      if (negative) begin
         entry.is_minus = 1'b1;
         entry.digit    = '0;
         entry.last     = 1'b0;
         digits_expected.push_back(entry);
      end
      for (int k = count - 1; k >= 0; k--) begin
         entry.is_minus = 1'b0;
         entry.digit    = stack[k];
         entry.last     = (k == 0);
         digits_expected.push_back(entry);
      end
   endfunction

   function automatic void queue_request(input logic mode,
                                         input logic [itrd_pkg::VALUE_W-1:0] value);
      itrd_pkg::req_type item;
      item.mode  = mode;
      item.value = value;
      number_queue.push_back(item);
   endfunction

   // Mix full-range values, values of every magnitude, small values of either
   // sign and values next to powers of two.
   function automatic itrd_pkg::req_type random_request();
      itrd_pkg::req_type            item;
      logic [itrd_pkg::VALUE_W-1:0] raw;
      raw       = {$urandom, $urandom};
      item.mode = $urandom_range(0, 1) ? itrd_pkg::MODE_UNSIGNED64 : itrd_pkg::MODE_SIGNED32;
      case ($urandom_range(0, 3))
         0: item.value = raw;
         1: item.value = raw >> $urandom_range(0, 63);
         2: item.value = $urandom_range(0, 1) ? 64'($urandom_range(0, 100))
                                              : -64'($urandom_range(0, 100));
         default: item.value = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
      endcase
      return item;
   endfunction

   // Driver: hold a request until it is taken, predict its digits at the
   // handshake, then insert a gap or present the next pending request.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_digits(req_payload);
            send_gap = sender_steady ? 0 : pick_gap();
         end
         if (!(req_valid && !req_ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (number_queue.size() != 0) begin
               req_payload <= number_queue.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each taken result against the oldest expected digit,
   // then decide whether to accept next cycle.
   always @(posedge clock) begin : monitor_proc
      itrd_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (digits_expected.size() == 0) begin
               report_mismatch("result with nothing expected, digit", rsp_payload.digit, 0);
            end else begin
               want = digits_expected.pop_front();
               if (rsp_payload.is_minus !== want.is_minus)
                  report_mismatch("is_minus", rsp_payload.is_minus, want.is_minus);
               if (rsp_payload.digit !== want.digit)
                  report_mismatch("digit", rsp_payload.digit, want.digit);
               if (rsp_payload.last !== want.last)
                  report_mismatch("last", rsp_payload.last, want.last);
            end
         end
         // Start a long hold-off when one is asked for; count it down here.
         if (squeeze_served != squeeze_requests) begin
            squeeze_served = squeeze_requests;
            squeeze_left   = SQUEEZE_CYCLES;
         end
         if (squeeze_left > 0) begin
            squeeze_left--;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else if (receiver_steady || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
         end else begin
            recv_gap = pick_gap();
            rsp_ready <= 1'b0;
         end
      end
   end

   // Watchdog: end the run when nothing moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("integer_to_radix_digits_tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Wait until every request is taken and every digit has come back, then
   // let the block settle. Poll on the falling edge to stay clear of the
   // clocked processes; return on a rising edge.
   task automatic wait_until_drained();
      do @(negedge clock);
      while (number_queue.size() != 0 || req_valid || digits_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the radix register; call only while the block is idle.
   task automatic write_radix(input logic [itrd_pkg::RADIX_W-1:0] setting);
      @(posedge clock);
      csr_data  <= setting;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      csr_valid     <= 1'b0;
      radix_setting  = setting;
   endtask

   initial begin
      logic [itrd_pkg::RADIX_W-1:0] pass_radix [10];
      int                           pass;
      pass_radix = '{7'd2, 7'd10, 7'd16, 7'd64, 7'd127, 7'd0, 7'd1, 7'd3, 7'd36, 7'd7};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset radix of ten: zero in both modes,
      // signed extremes including the most negative value, garbage in the
      // upper half of signed requests, and unsigned extremes.
      queue_request(itrd_pkg::MODE_SIGNED32,   64'd0);
      queue_request(itrd_pkg::MODE_UNSIGNED64, 64'd0);
      queue_request(itrd_pkg::MODE_SIGNED32,   64'd9);
      queue_request(itrd_pkg::MODE_SIGNED32,   64'h0000_0000_FFFF_FFFF);
      queue_request(itrd_pkg::MODE_SIGNED32,   64'h0000_0000_7FFF_FFFF);
      queue_request(itrd_pkg::MODE_SIGNED32,   64'h0000_0000_8000_0000);
      queue_request(itrd_pkg::MODE_SIGNED32,   64'hDEAD_BEEF_0000_0123);
      queue_request(itrd_pkg::MODE_SIGNED32,   64'hFFFF_FFFF_8000_0001);
      queue_request(itrd_pkg::MODE_UNSIGNED64, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_request(itrd_pkg::MODE_UNSIGNED64, 64'h8000_0000_0000_0000);
      queue_request(itrd_pkg::MODE_UNSIGNED64, 64'd10);
      wait_until_drained();

      // Radix zero acts as two: the longest digit string.
      write_radix(7'd0);
      queue_request(itrd_pkg::MODE_UNSIGNED64, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_request(itrd_pkg::MODE_SIGNED32,   64'h0000_0000_8000_0000);
      wait_until_drained();

      write_radix(7'd1);
      queue_request(itrd_pkg::MODE_UNSIGNED64, 64'd5);
      wait_until_drained();

      write_radix(7'd64);
      queue_request(itrd_pkg::MODE_UNSIGNED64, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_request(itrd_pkg::MODE_UNSIGNED64, 64'd63);
      queue_request(itrd_pkg::MODE_UNSIGNED64, 64'd64);
      wait_until_drained();

      // Radix above the top clamps to sixty-four.
      write_radix(7'd127);
      queue_request(itrd_pkg::MODE_UNSIGNED64, 64'd4095);
      queue_request(itrd_pkg::MODE_SIGNED32,   64'h0000_0000_FFFF_FFFF);
      wait_until_drained();

      write_radix(7'd65);
      queue_request(itrd_pkg::MODE_UNSIGNED64, 64'd64);
      wait_until_drained();

      // Random part: one pass per radix, some passes without any idling, one
      // with the receiver holding off while the sender keeps offering.
      for (pass = 0; pass < 10; pass++) begin
         sender_steady   = (pass % 4 == 1) || (pass == 4);
         receiver_steady = (pass % 4 == 1);
         write_radix(pass == 9 ? itrd_pkg::RADIX_W'($urandom_range(0, 127))
                               : pass_radix[pass]);
         if (pass == 4) squeeze_requests++;
         repeat (ITEMS_PER_PASS) number_queue.push_back(random_request());
         wait_until_drained();
      end

      if (error_count == 0) begin
         $display("integer_to_radix_digits_tb: clean");
      end else begin
         $display("integer_to_radix_digits_tb: errors");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/itrd_pkg.sv
design/itrd_ctrl.sv
design/itrd_datapath.sv
design/integer_to_radix_digits.sv
test/integer_to_radix_digits_tb.sv
